### sv/rtpp_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// rtpp_pkg: shared types and constants of the RTP header packetizer
// Holds the descriptor passed from the classifier to the serializer, the
// status and phase codes and the fixed RTP header constants.
// ============================================================================
package rtpp_pkg;

    // Input function codes.
    localparam logic FUNC_OPEN = 1'b0;
    localparam logic FUNC_BYTE = 1'b1;

    // Status codes of a result.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_SESS   = 2'd1;
    localparam logic [1:0] ST_ALREADY    = 2'd2;
    localparam logic [1:0] ST_NOT_OPEN   = 2'd3;

    // Session phase codes.
    localparam logic [1:0] PH_CLOSED = 2'd0;
    localparam logic [1:0] PH_FRESH  = 2'd1;
    localparam logic [1:0] PH_SENT   = 2'd2;

    // Format codes and the payload types they select.
    localparam logic [1:0] FMT_L16 = 2'd0;
    localparam logic [1:0] FMT_L24 = 2'd1;
    localparam logic [6:0] PT_L16   = 7'd96;
    localparam logic [6:0] PT_L24   = 7'd100;
    localparam logic [6:0] PT_OTHER = 7'd99;

    localparam logic [15:0] SEQ_INIT      = 16'd1000;
    localparam logic [7:0]  RTP_V2_BYTE   = 8'h80;
    localparam logic [3:0]  HDR_LAST_IDX  = 4'd12;
    localparam logic [31:0] SRC_ID_RESET  = 32'd33144096;

    // What the serializer has to produce for one request.
    typedef enum logic [1:0] {
        K_STATUS,
        K_BYTE,
        K_HDR
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [1:0]  status;
        logic [7:0]  pbyte;
        logic        last;
        logic        mark;
        logic [6:0]  ptype;
        logic [15:0] seq;
        logic [31:0] ts;
    } t_desc;

    function automatic logic [6:0] f_fmt_type(input logic [1:0] fmt);
        logic [6:0] pt;
        unique case (fmt)
            FMT_L16: pt = PT_L16;
            FMT_L24: pt = PT_L24;
            default: pt = PT_OTHER;
        endcase
        return pt;
    endfunction

endpackage

### sv/rtpp_front.sv
`timescale 1ns / 1ps
// ============================================================================
// rtpp_front: request classifier and session state
// Checks each accepted request against the session table, updates the
// table and builds one descriptor for the serializer.
// ============================================================================
module rtpp_front #(
    parameter int SESSIONS = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic            i_func,
    input  logic [2:0]      i_session,
    input  logic [1:0]      i_format,
    input  logic [7:0]      i_payload_byte,
    input  logic            i_first,
    input  logic            i_last,
    input  logic [31:0]     i_time_ms,
    output rtpp_pkg::t_desc o_desc
);
    import rtpp_pkg::*;

    localparam int IW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

    logic [1:0]  r_phase [SESSIONS];
    logic [15:0] r_seq   [SESSIONS];
    logic [6:0]  r_type  [SESSIONS];

    logic          w_in_range;
    logic [IW-1:0] w_idx;
    logic [1:0]    w_phase;
    logic [15:0]   w_seq;
    logic [6:0]    w_type;
    logic          w_open_ok;
    logic          w_hdr;
    logic [15:0]   n_seq;

    always_comb begin
        w_in_range = int'(i_session) < SESSIONS;
        w_idx      = i_session[IW-1:0];
        w_phase    = w_in_range ? r_phase[w_idx] : PH_CLOSED;
        w_seq      = w_in_range ? r_seq[w_idx]   : '0;
        w_type     = w_in_range ? r_type[w_idx]  : '0;
        n_seq      = w_seq + 16'd1;

        w_open_ok  = w_in_range && (i_func == FUNC_OPEN) && (w_phase == PH_CLOSED);
        w_hdr      = w_in_range && (i_func == FUNC_BYTE) && (w_phase != PH_CLOSED)
                     && i_first;

        o_desc.kind   = K_STATUS;
        o_desc.status = ST_OK;
        o_desc.pbyte  = i_payload_byte;
        o_desc.last   = i_last;
        o_desc.mark   = (w_phase == PH_FRESH);
        o_desc.ptype  = w_type;
        o_desc.seq    = n_seq;
        o_desc.ts     = i_time_ms;

        priority if (!w_in_range) begin
            o_desc.status = ST_BAD_SESS;
        end else if (i_func == FUNC_OPEN) begin
            o_desc.status = w_open_ok ? ST_OK : ST_ALREADY;
        end else if (w_phase == PH_CLOSED) begin
            o_desc.status = ST_NOT_OPEN;
        end else if (i_first) begin
            o_desc.kind = K_HDR;
        end else begin
            o_desc.kind = K_BYTE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SESSIONS; i++) begin
                r_phase[i] <= PH_CLOSED;
                r_seq[i]   <= '0;
                r_type[i]  <= '0;
            end
        end else if (i_accept) begin
            if (w_open_ok) begin
                r_phase[w_idx] <= PH_FRESH;
                r_seq[w_idx]   <= SEQ_INIT;
                r_type[w_idx]  <= f_fmt_type(i_format);
            end
            if (w_hdr) begin
                r_seq[w_idx] <= n_seq;
                if (w_phase == PH_FRESH) begin
                    r_phase[w_idx] <= PH_SENT;
                end
            end
        end
    end

endmodule

### sv/rtpp_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// rtpp_queue: descriptor queue between classifier and serializer
// A small register queue that lets either side stall on its own.
// ============================================================================
module rtpp_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rtpp_pkg::t_desc i_desc,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output rtpp_pkg::t_desc o_desc
);
    import rtpp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_desc         r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_desc  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

### sv/rtpp_back.sv
`timescale 1ns / 1ps
// ============================================================================
// rtpp_back: result serializer
// Turns each descriptor into one status result, one payload byte, or a
// twelve-byte RTP header followed by the payload byte, into an output
// register.
// ============================================================================
module rtpp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  rtpp_pkg::t_desc i_desc,
    output logic            o_q_pop,
    input  logic [31:0]     i_source_id,
    input  logic            i_pop,
    output logic            o_empty,
    output logic            o_has_byte,
    output logic [7:0]      o_out_byte,
    output logic            o_out_last,
    output logic [1:0]      o_status
);
    import rtpp_pkg::*;

    logic [3:0] r_idx;
    logic       r_valid;
    logic       r_has;
    logic [7:0] r_byte;
    logic       r_last;
    logic [1:0] r_status;

    logic       w_load;
    logic       w_final;
    logic       n_has;
    logic [7:0] n_byte;
    logic       n_last;
    logic [1:0] n_status;

    always_comb begin
        n_has    = 1'b1;
        n_byte   = i_desc.pbyte;
        n_last   = i_desc.last;
        n_status = ST_OK;
        w_final  = 1'b1;
        unique case (i_desc.kind)
            K_HDR: begin
                w_final = (r_idx == HDR_LAST_IDX);
                if (!w_final) begin
                    n_last = 1'b0;
                end
                unique case (r_idx)
                    4'd0:    n_byte = RTP_V2_BYTE;
                    4'd1:    n_byte = {i_desc.mark, i_desc.ptype};
                    4'd2:    n_byte = i_desc.seq[15:8];
                    4'd3:    n_byte = i_desc.seq[7:0];
                    4'd4:    n_byte = i_desc.ts[31:24];
                    4'd5:    n_byte = i_desc.ts[23:16];
                    4'd6:    n_byte = i_desc.ts[15:8];
                    4'd7:    n_byte = i_desc.ts[7:0];
                    4'd8:    n_byte = i_source_id[31:24];
                    4'd9:    n_byte = i_source_id[23:16];
                    4'd10:   n_byte = i_source_id[15:8];
                    4'd11:   n_byte = i_source_id[7:0];
                    default: n_byte = i_desc.pbyte;
                endcase
            end
            K_BYTE: begin
                n_has = 1'b1;
            end
            default: begin
                n_has    = 1'b0;
                n_byte   = '0;
                n_last   = 1'b1;
                n_status = i_desc.status;
            end
        endcase
        w_load  = i_q_valid && (!r_valid || i_pop);
        o_q_pop = w_load && w_final;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_idx   <= w_final ? 4'd0 : r_idx + 4'd1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_has    <= n_has;
            r_byte   <= n_byte;
            r_last   <= n_last;
            r_status <= n_status;
        end
    end

    assign o_empty    = !r_valid;
    assign o_has_byte = r_has;
    assign o_out_byte = r_byte;
    assign o_out_last = r_last;
    assign o_status   = r_status;

endmodule

### sv/rtp_header_packetizer_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// rtp_header_packetizer_unit: multi-session RTP fixed-header packetizer
// Opens sessions and wraps payload bytes with the 12-byte RTP header.
// ============================================================================
// Usage:
// Requests enter through a queue-style port: a request is taken on a rising
// edge with push high and full low. An open request answers with one status
// result; a payload byte on an open session passes through, and a byte that
// starts a packet is preceded by the twelve header bytes (13 results).
// Results leave through a queue-style port: the oldest result sits on the
// result ports while empty is low and is taken on an edge with pop high.
// The source identifier is written through its own valid/ready channel,
// which is always ready; write it only while the block is idle.
// When nothing is waiting ahead of it, an accepted request passes through
// the descriptor queue and then the output register, where its result
// shows on the ports and can be taken.
// Throughput: one request per cycle while full is low, one result per cycle
// while pop is high. The serializer emits one byte per cycle while its
// output register is free, so a packet start yields 13 bytes; a 4-entry
// descriptor queue absorbs requests meanwhile and full rises only when filled.
// When the receiver holds pop low, the output register holds its result,
// the serializer stops, the queue fills and full then stalls the sender.
// Reset closes all sessions, empties the queue and output register and
// loads the source identifier with 33144096.
// ============================================================================
module rtp_header_packetizer_unit #(
    parameter int SESSIONS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request side
    input  logic        push,
    output logic        full,
    input  logic        i_func,
    input  logic [2:0]  i_session,
    input  logic [1:0]  i_format,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_first,
    input  logic        i_last,
    input  logic [31:0] i_time_ms,
    // Result side
    output logic        empty,
    input  logic        pop,
    output logic        o_has_byte,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    output logic [1:0]  o_status,
    // Source identifier write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);
    import rtpp_pkg::*;

    logic [31:0] r_source_id;
    logic        w_accept;
    t_desc       w_front_desc;
    t_desc       w_q_desc;
    logic        w_q_valid;
    logic        w_q_pop;

    // The register is a plain write target; it never stalls the channel.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_id <= SRC_ID_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_source_id <= i_cfg_data;
        end
    end

    // A request is taken whenever the descriptor queue has room.
    assign w_accept = push && !full;

    rtpp_front #(
        .SESSIONS (SESSIONS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_func         (i_func),
        .i_session      (i_session),
        .i_format       (i_format),
        .i_payload_byte (i_payload_byte),
        .i_first        (i_first),
        .i_last         (i_last),
        .i_time_ms      (i_time_ms),
        .o_desc         (w_front_desc)
    );

    rtpp_queue #(
        .DEPTH (4)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_desc  (w_front_desc),
        .o_full  (full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_desc  (w_q_desc)
    );

    // The serializer reads the live source identifier; the user must change it
    // only while no descriptor is pending, as the block does not enforce this.
    rtpp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_desc      (w_q_desc),
        .o_q_pop     (w_q_pop),
        .i_source_id (r_source_id),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_has_byte  (o_has_byte),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .o_status    (o_status)
    );

endmodule

### sv/rtpp_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// rtpp_checker: port-level checks of the RTP header packetizer
// Watches the result side over time and is bound to the top level.
// ============================================================================
module rtpp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic       o_has_byte,
    input logic [7:0] o_out_byte,
    input logic       o_out_last,
    input logic [1:0] o_status
);
    import rtpp_pkg::*;

    // Reset leaves both sides with nothing pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queue not clear after reset");

    // A waiting result holds until it is taken.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_has_byte) && $stable(o_out_byte)
                              && $stable(o_out_last) && $stable(o_status)))
        else $error("waiting result changed before it was taken");

    // An error status comes only on a status-only result.
    a_error_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_status != ST_OK))
            |-> (!o_has_byte && o_out_last && (o_out_byte == 8'd0)))
        else $error("error status carried with a packet byte");

    // A result without a byte always closes its request.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_has_byte) |-> (o_out_last && (o_out_byte == 8'd0)))
        else $error("status-only result without last");

endmodule

bind rtp_header_packetizer_unit rtpp_checker u_rtpp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .o_has_byte (o_has_byte),
    .o_out_byte (o_out_byte),
    .o_out_last (o_out_last),
    .o_status   (o_status)
);
